// ===== rtl/core/chunk_page_bitmap_allocator_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Chunk page bitmap allocator assertion macros
// Shared concurrent assertion forms for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef CHUNK_PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH
`define CHUNK_PAGE_BITMAP_ALLOCATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define CPBA_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CPBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/cpba_pkg.sv =====
// ----------------------------------------------------------------------------
// Chunk page bitmap allocator package
// Widths, codes, slot entry types and the run mask helper.
// ----------------------------------------------------------------------------
package cpba_pkg;

   localparam int ADDR_W          = 36;
   localparam int COUNT_W         = 4;
   localparam int PAGES_PER_CHUNK = 16;
   localparam int MAP_W           = PAGES_PER_CHUNK;
   localparam int PAGE_IDX_W      = $clog2(PAGES_PER_CHUNK);
   localparam int BASE_W          = ADDR_W - PAGE_IDX_W;
   localparam int DEF_NUM_CHUNKS  = 64;

   localparam logic [1:0] ACT_ALLOC = 2'd0;
   localparam logic [1:0] ACT_ADD   = 2'd1;
   localparam logic [1:0] ACT_FREE  = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   localparam logic [1:0] STAT_OK         = 2'd0;
   localparam logic [1:0] STAT_NO_ROOM    = 2'd1;
   localparam logic [1:0] STAT_TABLE_FULL = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND  = 2'd3;

   typedef enum logic [1:0] {
      FSM_CLEAR,
      FSM_IDLE,
      FSM_SCAN
   } fsm_state_type;

   typedef struct packed {
      logic              valid;
      logic [BASE_W-1:0] base;
      logic [MAP_W-1:0]  map;
   } slot_entry_type;

   typedef struct packed {
      logic              hit;
      logic              released;
      logic [ADDR_W-1:0] page;
      slot_entry_type    entry;
   } slot_eval_type;

   function automatic logic [MAP_W-1:0] run_mask(input logic [COUNT_W-1:0] count);
      logic [MAP_W:0] one_hot;
      one_hot = (MAP_W + 1)'(1) << count;
      return MAP_W'(one_hot - (MAP_W + 1)'(1));
   endfunction

endpackage

// ===== rtl/core/chunk_page_bitmap_allocator_unit.sv =====
// ----------------------------------------------------------------------------
// Chunk page bitmap allocator
// First-fit page run allocator over a table of chunks with page bitmaps.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its one result word
// appears on the rsp_ ports for a single cycle with rsp_strobe, and the
// receiver cannot stall it. The slot table sits in a single-port-read memory
// that one sequencer scans one slot per cycle through a shared slot evaluator;
// the read word is registered, evaluated combinationally, and the result word is
// registered, so a request is answered by the first slot that serves it, or with
// a failure status once the last slot has been evaluated. The unused action
// answers without a scan. A new request may be taken in the cycle in which the
// previous result is shown. After reset the table is cleared one slot per cycle,
// and busy stays high until the last slot has been cleared.
// ----------------------------------------------------------------------------
module chunk_page_bitmap_allocator_unit import cpba_pkg::*; #(
   parameter int NUM_CHUNKS = DEF_NUM_CHUNKS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_action,
   input  logic [ADDR_W-1:0]  req_page_addr,
   input  logic [COUNT_W-1:0] req_page_count,
   output logic               rsp_strobe,
   output logic [1:0]         rsp_status,
   output logic [ADDR_W-1:0]  rsp_result_page,
   output logic               rsp_chunk_released
);

   localparam int IDX_W = (NUM_CHUNKS > 1) ? $clog2(NUM_CHUNKS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_CHUNKS - 1);

   fsm_state_type      state_ff, state_in;
   logic [IDX_W-1:0]   scan_idx_ff, scan_idx_in;
   logic               issue_done_ff, issue_done_in;
   logic               pend_ff, pend_in;
   logic [IDX_W-1:0]   pend_idx_ff, pend_idx_in;
   logic [1:0]         act_ff, act_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               rsp_strobe_ff, rsp_strobe_in;
   logic [1:0]         rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]  rsp_page_ff, rsp_page_in;
   logic               rsp_rel_ff, rsp_rel_in;
   slot_entry_type     rd_data_ff;

   slot_entry_type     slot_mem [NUM_CHUNKS];
   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   slot_entry_type     mem_wdata;
   slot_eval_type      eval;
   logic [1:0]         fail_status;

   cpba_slot_eval u_slot_eval (
      .action     (act_ff),
      .page_addr  (addr_ff),
      .page_count (count_ff),
      .entry      (rd_data_ff),
      .eval       (eval)
   );

   always_ff @(posedge clock) begin
      if (mem_we) begin
         slot_mem[mem_waddr] <= mem_wdata;
      end
      rd_data_ff <= slot_mem[scan_idx_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= FSM_CLEAR;
         scan_idx_ff   <= '0;
         issue_done_ff <= 1'b0;
         pend_ff       <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_idx_ff   <= scan_idx_in;
         issue_done_ff <= issue_done_in;
         pend_ff       <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff   <= pend_idx_in;
      act_ff        <= act_in;
      addr_ff       <= addr_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_page_ff   <= rsp_page_in;
      rsp_rel_ff    <= rsp_rel_in;
   end

   always_comb begin
      case (act_ff)
         ACT_ALLOC: fail_status = STAT_NO_ROOM;
         ACT_ADD:   fail_status = STAT_TABLE_FULL;
         ACT_FREE:  fail_status = STAT_NOT_FOUND;
         default:   fail_status = STAT_OK;
      endcase
   end

   always_comb begin
      state_in      = state_ff;
      scan_idx_in   = scan_idx_ff;
      issue_done_in = issue_done_ff;
      pend_in       = pend_ff;
      pend_idx_in   = pend_idx_ff;
      act_in        = act_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_page_in   = rsp_page_ff;
      rsp_rel_in    = rsp_rel_ff;
      mem_we        = 1'b0;
      mem_waddr     = scan_idx_ff;
      mem_wdata     = '0;

      case (state_ff)
         FSM_CLEAR: begin
            mem_we = 1'b1;
            if (scan_idx_ff == LAST_IDX) begin
               scan_idx_in = '0;
               state_in    = FSM_IDLE;
            end else begin
               scan_idx_in = scan_idx_ff + IDX_W'(1);
            end
         end
         FSM_IDLE: begin
            if (start) begin
               act_in        = req_action;
               addr_in       = req_page_addr;
               count_in      = req_page_count;
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               pend_in       = 1'b0;
               if (req_action == ACT_NONE) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_page_in   = '0;
                  rsp_rel_in    = 1'b0;
               end else begin
                  state_in = FSM_SCAN;
               end
            end
         end
         FSM_SCAN: begin
            pend_in     = !issue_done_ff;
            pend_idx_in = scan_idx_ff;
            if (!issue_done_ff) begin
               if (scan_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (pend_ff) begin
               if (eval.hit) begin
                  mem_we        = 1'b1;
                  mem_waddr     = pend_idx_ff;
                  mem_wdata     = eval.entry;
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = STAT_OK;
                  rsp_page_in   = eval.page;
                  rsp_rel_in    = eval.released;
                  pend_in       = 1'b0;
                  scan_idx_in   = '0;
                  state_in      = FSM_IDLE;
               end else if (pend_idx_ff == LAST_IDX) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = fail_status;
                  rsp_page_in   = '0;
                  rsp_rel_in    = 1'b0;
                  pend_in       = 1'b0;
                  scan_idx_in   = '0;
                  state_in      = FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   assign busy               = state_ff != FSM_IDLE;
   assign rsp_strobe         = rsp_strobe_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_page    = rsp_page_ff;
   assign rsp_chunk_released = rsp_rel_ff;

endmodule

// ===== rtl/core/cpba_slot_eval.sv =====
// ----------------------------------------------------------------------------
// Chunk page bitmap allocator slot evaluator
// Decides whether one slot serves the current request and forms its update.
// ----------------------------------------------------------------------------
module cpba_slot_eval import cpba_pkg::*; (
   input  logic [1:0]         action,
   input  logic [ADDR_W-1:0]  page_addr,
   input  logic [COUNT_W-1:0] page_count,
   input  slot_entry_type     entry,
   output slot_eval_type      eval
);

   logic [MAP_W-1:0]      pat;
   logic [MAP_W-1:0]      free_map;
   logic [MAP_W-1:0]      fits;
   logic                  found;
   logic [PAGE_IDX_W-1:0] pos;
   logic [MAP_W-1:0]      clr_map;
   logic [MAP_W-1:0]      left_map;
   logic                  base_match;

   always_comb begin
      pat      = run_mask(page_count);
      free_map = ~entry.map;
      found    = 1'b0;
      pos      = '0;
      for (int k = 0; k < MAP_W; k++) begin
         fits[k] = ((free_map >> k) & pat) == pat;
      end
      for (int k = MAP_W - 1; k >= 0; k--) begin
         if (fits[k]) begin
            found = 1'b1;
            pos   = PAGE_IDX_W'(k);
         end
      end
      clr_map    = pat << page_addr[PAGE_IDX_W-1:0];
      left_map   = entry.map & ~clr_map;
      base_match = entry.valid && (entry.base == page_addr[ADDR_W-1:PAGE_IDX_W]);

      eval       = '0;
      eval.entry = entry;
      case (action)
         ACT_ALLOC: begin
            eval.hit       = entry.valid && (page_count != '0) && found;
            eval.entry.map = entry.map | (pat << pos);
            eval.page      = {entry.base, pos};
         end
         ACT_ADD: begin
            eval.hit         = !entry.valid;
            eval.entry.valid = 1'b1;
            eval.entry.base  = page_addr[ADDR_W-1:PAGE_IDX_W];
            eval.entry.map   = pat;
            eval.page        = {page_addr[ADDR_W-1:PAGE_IDX_W], PAGE_IDX_W'(0)};
         end
         ACT_FREE: begin
            eval.hit         = base_match;
            eval.entry.map   = left_map;
            eval.released    = left_map == '0;
            eval.entry.valid = left_map != '0;
            eval.page        = (left_map == '0) ? {entry.base, PAGE_IDX_W'(0)} : '0;
         end
         default: begin
            eval.hit = 1'b0;
         end
      endcase
   end

endmodule

// ===== rtl/core/cpba_checker.sv =====
// ----------------------------------------------------------------------------
// Chunk page bitmap allocator checker
// Port-level assertions on request handling and result words.
// ----------------------------------------------------------------------------
`include "chunk_page_bitmap_allocator_unit_assert.svh"

module cpba_checker import cpba_pkg::*; (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic [1:0]         req_action,
   input logic               rsp_strobe,
   input logic [1:0]         rsp_status,
   input logic [ADDR_W-1:0]  rsp_result_page,
   input logic               rsp_chunk_released
);

   logic req_take;
   logic req_scan;
   logic none_take;
   logic none_word;
   logic fail_word;
   logic fail_clean;
   logic rel_word;

   assign req_take   = start && !busy;
   assign req_scan   = req_take && (req_action != ACT_NONE);
   assign none_take  = req_take && (req_action == ACT_NONE);
   assign none_word  = rsp_strobe && (rsp_status == STAT_OK) && (rsp_result_page == '0)
                       && !rsp_chunk_released;
   assign fail_word  = rsp_strobe && (rsp_status != STAT_OK);
   assign fail_clean = (rsp_result_page == '0) && !rsp_chunk_released;
   assign rel_word   = rsp_strobe && rsp_chunk_released;

   `CPBA_ASSERT_NEXT(a_scan_sets_busy, clock, reset, req_scan, busy, "scan request did not raise busy")
   `CPBA_ASSERT_NEXT(a_none_answers, clock, reset, none_take, none_word, "unused action word is wrong")
   `CPBA_ASSERT_SAME(a_fail_zero, clock, reset, fail_word, fail_clean, "failed word carries data")
   `CPBA_ASSERT_SAME(a_release_ok, clock, reset, rel_word, (rsp_status == STAT_OK), "release flag outside an ok word")

endmodule

bind chunk_page_bitmap_allocator_unit cpba_checker u_cpba_checker (
   .clock              (clock),
   .reset              (reset),
   .start              (start),
   .busy               (busy),
   .req_action         (req_action),
   .rsp_strobe         (rsp_strobe),
   .rsp_status         (rsp_status),
   .rsp_result_page    (rsp_result_page),
   .rsp_chunk_released (rsp_chunk_released)
);
